### hw/rtl/ipls_pkg.sv
// ---------------------------------------------------------------------------
// Idle power ladder sequencer package
// Shared types and codes for the ladder sequencer and its threshold unit.
// ---------------------------------------------------------------------------
`default_nettype none

package ipls_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_DIM_AFTER    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_AFTER   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SLEEP_AFTER  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_CAP    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_SLICE   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SLEEP_SLICE  = 3'd5;

  // Ladder rungs.
  localparam logic [1:0] RUNG_ACTIVE = 2'd0;
  localparam logic [1:0] RUNG_DIM    = 2'd1;
  localparam logic [1:0] RUNG_IDLE   = 2'd2;
  localparam logic [1:0] RUNG_SLEEP  = 2'd3;

  // Hook actions carried by a result beat.
  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_DIM_ON    = 3'd1,
    ACT_RADIO_REL = 3'd2,
    ACT_PANEL_OFF = 3'd3,
    ACT_SAVE      = 3'd4,
    ACT_PANEL_ON  = 3'd5,
    ACT_DIM_OFF   = 3'd6
  } action_e;

  // Which threshold the shared comparator looks at.
  typedef enum logic [1:0] {
    SEL_SLEEP = 2'd0,
    SEL_IDLE  = 2'd1,
    SEL_DIM   = 2'd2
  } cmp_sel_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CMP  = 2'd1,
    ST_EMIT = 2'd2
  } state_e;

  // The three thresholds handed to the comparator as one group.
  typedef struct packed {
    logic [TimeW-1:0] sleep_after;
    logic [TimeW-1:0] idle_after;
    logic [TimeW-1:0] dim_after;
  } thresh_t;

endpackage

`default_nettype wire

### hw/rtl/ipls_cmp.sv
// ---------------------------------------------------------------------------
// Idle power ladder threshold comparator
// One unsigned greater-or-equal compare, shared over the three thresholds.
// ---------------------------------------------------------------------------
`default_nettype none

module ipls_cmp (
  input  wire logic [ipls_pkg::TimeW-1:0] time_i,
  input  wire ipls_pkg::thresh_t          thresh_i,
  input  wire ipls_pkg::cmp_sel_e         sel_i,
  output logic                            ge_o
);

  logic [ipls_pkg::TimeW-1:0] limit;

  always_comb begin
    case (sel_i)
      ipls_pkg::SEL_SLEEP: limit = thresh_i.sleep_after;
      ipls_pkg::SEL_IDLE:  limit = thresh_i.idle_after;
      ipls_pkg::SEL_DIM:   limit = thresh_i.dim_after;
      default:             limit = thresh_i.dim_after;
    endcase
  end

  assign ge_o = (time_i >= limit);

endmodule

`default_nettype wire

### hw/rtl/idle_power_ladder_sequencer.sv
// ---------------------------------------------------------------------------
// Idle power ladder sequencer
// Picks a target power rung from the idle time and walks the ladder towards
// it, giving one result beat per hook action (one no-action beat if none).
// ---------------------------------------------------------------------------
// Usage:
// The input channel takes one service beat (idle time, radio hold flag and
// wanted frame rate). in_stall_o is high from the accepting edge until the
// last result beat of that item has been taken, so one item is in flight.
// After acceptance a single shared comparator checks the sleep, idle and dim
// thresholds in that order, one per cycle, stopping at the first that is
// reached. Then one to four result beats follow, one per cycle while the
// receiver does not stall; the last carries last_of_run_o. Time from acceptance
// until in_stall_o falls depends on the compares (at most three), the beats
// (at most four) and receiver stalls. When the receiver stalls the current
// result beat holds unchanged and the sequencer waits. Reset returns the
// ladder to the active rung and loads the default thresholds, frame cap and
// slices. Configuration is written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i; the user must write it only while the block is idle, which the
// block itself does not enforce. Indexes beyond the register list are ignored.
// ---------------------------------------------------------------------------
`default_nettype none

module idle_power_ladder_sequencer #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [ipls_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [ipls_pkg::CfgDataW-1:0]     cfg_wdata_i,
  // Service item channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [31:0]                       idle_time_ms_i,
  input  wire logic                              radio_held_i,
  input  wire logic [7:0]                        wanted_fps_i,
  // Result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [2:0]                             action_o,
  output logic [1:0]                             ladder_rung_o,
  output logic [7:0]                             frame_rate_o,
  output logic [15:0]                            cpu_slice_ms_o,
  output logic                                   last_of_run_o
);

  // Only the low TIME_BITS bits of the idle time take part in the compare.
  localparam logic [31:0] TimeMask =
    (TIME_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << TIME_BITS) - 32'd1);

  // First hook action of a run from rung s towards rung w.
  function automatic ipls_pkg::action_e first_act(logic [1:0] s, logic [1:0] w);
    ipls_pkg::action_e a;
    a = ipls_pkg::ACT_NONE;
    if (w > s) begin
      if (s == ipls_pkg::RUNG_ACTIVE) begin
        a = ipls_pkg::ACT_DIM_ON;
      end else if (s == ipls_pkg::RUNG_DIM) begin
        a = ipls_pkg::ACT_RADIO_REL;
      end
    end else if (w < s) begin
      if (s >= ipls_pkg::RUNG_IDLE) begin
        if (w <= ipls_pkg::RUNG_DIM) begin
          a = ipls_pkg::ACT_PANEL_ON;
        end
      end else begin
        a = ipls_pkg::ACT_DIM_OFF;
      end
    end
    return a;
  endfunction

  // Action that follows a within the same run, towards rung w.
  function automatic ipls_pkg::action_e next_act(ipls_pkg::action_e a, logic [1:0] w);
    ipls_pkg::action_e n;
    n = ipls_pkg::ACT_NONE;
    case (a)
      ipls_pkg::ACT_DIM_ON:    n = (w >= ipls_pkg::RUNG_IDLE) ? ipls_pkg::ACT_RADIO_REL
                                                            : ipls_pkg::ACT_NONE;
      ipls_pkg::ACT_RADIO_REL: n = ipls_pkg::ACT_PANEL_OFF;
      ipls_pkg::ACT_PANEL_OFF: n = ipls_pkg::ACT_SAVE;
      ipls_pkg::ACT_PANEL_ON:  n = (w == ipls_pkg::RUNG_ACTIVE) ? ipls_pkg::ACT_DIM_OFF
                                                              : ipls_pkg::ACT_NONE;
      default:                 n = ipls_pkg::ACT_NONE;
    endcase
    return n;
  endfunction

  // Rung reached by the step an action belongs to.
  function automatic logic [1:0] act_rung(ipls_pkg::action_e a, logic [1:0] w);
    logic [1:0] r;
    case (a)
      ipls_pkg::ACT_DIM_ON:    r = ipls_pkg::RUNG_DIM;
      ipls_pkg::ACT_RADIO_REL: r = ipls_pkg::RUNG_IDLE;
      ipls_pkg::ACT_PANEL_OFF: r = ipls_pkg::RUNG_IDLE;
      ipls_pkg::ACT_SAVE:      r = ipls_pkg::RUNG_IDLE;
      ipls_pkg::ACT_PANEL_ON:  r = ipls_pkg::RUNG_DIM;
      ipls_pkg::ACT_DIM_OFF:   r = ipls_pkg::RUNG_ACTIVE;
      default:                 r = w;
    endcase
    return r;
  endfunction

  // Configuration registers.
  logic [31:0] dim_after_q, idle_after_q, sleep_after_q;
  logic [7:0]  frame_cap_q;
  logic [15:0] idle_slice_q, sleep_slice_q;

  // Sequencer control.
  ipls_pkg::state_e   state_q, state_d;
  ipls_pkg::cmp_sel_e sel_q, sel_d;
  ipls_pkg::action_e  act_q, act_d;
  logic [1:0]         cur_rung_q, cur_rung_d;
  logic [1:0]         want_q, want_d;

  // Captured item.
  logic [31:0] time_q;
  logic        held_q;
  logic [7:0]  fps_q;

  logic              in_acc, out_acc, ge, cmp_done;
  logic [1:0]        tgt;
  ipls_pkg::action_e nxt_act;
  ipls_pkg::thresh_t thresh;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  assign thresh.sleep_after = sleep_after_q;
  assign thresh.idle_after  = idle_after_q;
  assign thresh.dim_after   = dim_after_q;

  ipls_cmp u_cmp (
    .time_i   (time_q),
    .thresh_i (thresh),
    .sel_i    (sel_q),
    .ge_o     (ge)
  );

  // The compare sequence ends at the first threshold reached, or after dim.
  assign cmp_done = ge || (sel_q == ipls_pkg::SEL_DIM);

  always_comb begin
    tgt = ipls_pkg::RUNG_ACTIVE;
    if (ge) begin
      case (sel_q)
        ipls_pkg::SEL_SLEEP: tgt = ipls_pkg::RUNG_SLEEP;
        ipls_pkg::SEL_IDLE:  tgt = ipls_pkg::RUNG_IDLE;
        default:             tgt = ipls_pkg::RUNG_DIM;
      endcase
    end
    // A held radio job keeps the ladder at dim at most.
    if (held_q && tgt > ipls_pkg::RUNG_DIM) begin
      tgt = ipls_pkg::RUNG_DIM;
    end
  end

  assign nxt_act = next_act(act_q, want_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ipls_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = ipls_pkg::ST_CMP;
        end
      end
      ipls_pkg::ST_CMP: begin
        if (cmp_done) begin
          state_d = ipls_pkg::ST_EMIT;
        end
      end
      ipls_pkg::ST_EMIT: begin
        if (out_acc && nxt_act == ipls_pkg::ACT_NONE) begin
          state_d = ipls_pkg::ST_IDLE;
        end
      end
      default: state_d = ipls_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates and outputs.
  always_comb begin
    sel_d      = sel_q;
    act_d      = act_q;
    want_d     = want_q;
    cur_rung_d = cur_rung_q;
    case (state_q)
      ipls_pkg::ST_IDLE: begin
        sel_d = ipls_pkg::SEL_SLEEP;
      end
      ipls_pkg::ST_CMP: begin
        if (cmp_done) begin
          want_d = tgt;
          act_d  = first_act(cur_rung_q, tgt);
        end else if (sel_q == ipls_pkg::SEL_SLEEP) begin
          sel_d = ipls_pkg::SEL_IDLE;
        end else begin
          sel_d = ipls_pkg::SEL_DIM;
        end
      end
      ipls_pkg::ST_EMIT: begin
        if (out_acc) begin
          act_d = nxt_act;
          if (nxt_act == ipls_pkg::ACT_NONE) begin
            cur_rung_d = want_q;
          end
        end
      end
      default: begin
        sel_d = ipls_pkg::SEL_SLEEP;
      end
    endcase
  end

  assign in_stall_o    = (state_q != ipls_pkg::ST_IDLE);
  assign out_valid_o   = (state_q == ipls_pkg::ST_EMIT);
  assign action_o      = act_q;
  assign last_of_run_o = (nxt_act == ipls_pkg::ACT_NONE);
  // The last beat always shows the final rung, which folds in a silent step.
  assign ladder_rung_o = last_of_run_o ? want_q : act_rung(act_q, want_q);
  assign frame_rate_o  = (want_q >= ipls_pkg::RUNG_IDLE && fps_q > frame_cap_q) ?
                         frame_cap_q : fps_q;
  always_comb begin
    case (want_q)
      ipls_pkg::RUNG_IDLE:  cpu_slice_ms_o = idle_slice_q;
      ipls_pkg::RUNG_SLEEP: cpu_slice_ms_o = sleep_slice_q;
      default:              cpu_slice_ms_o = 16'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ipls_pkg::ST_IDLE;
      sel_q         <= ipls_pkg::SEL_SLEEP;
      act_q         <= ipls_pkg::ACT_NONE;
      want_q        <= ipls_pkg::RUNG_ACTIVE;
      cur_rung_q    <= ipls_pkg::RUNG_ACTIVE;
      dim_after_q   <= 32'd15000;
      idle_after_q  <= 32'd30000;
      sleep_after_q <= 32'd120000;
      frame_cap_q   <= 8'd10;
      idle_slice_q  <= 16'd50;
      sleep_slice_q <= 16'd200;
    end else begin
      state_q    <= state_d;
      sel_q      <= sel_d;
      act_q      <= act_d;
      want_q     <= want_d;
      cur_rung_q <= cur_rung_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ipls_pkg::CFG_DIM_AFTER:   dim_after_q   <= cfg_wdata_i;
          ipls_pkg::CFG_IDLE_AFTER:  idle_after_q  <= cfg_wdata_i;
          ipls_pkg::CFG_SLEEP_AFTER: sleep_after_q <= cfg_wdata_i;
          ipls_pkg::CFG_FRAME_CAP:   frame_cap_q   <= cfg_wdata_i[7:0];
          ipls_pkg::CFG_IDLE_SLICE:  idle_slice_q  <= cfg_wdata_i[15:0];
          ipls_pkg::CFG_SLEEP_SLICE: sleep_slice_q <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
    end
  end

  // Item capture, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      time_q <= idle_time_ms_i & TimeMask;
      held_q <= radio_held_i;
      fps_q  <= wanted_fps_i;
    end
  end

  // A taken last beat commits the target as the new current rung.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && last_of_run_o |=> cur_rung_q == $past(want_q))
    else $error("ladder rung not committed after last beat");

  // An accepted item always starts the compare at the sleep threshold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ipls_pkg::ST_CMP && sel_q == ipls_pkg::SEL_SLEEP)
    else $error("compare sequence did not start at sleep threshold");

  // A beat without an action closes its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ipls_pkg::ACT_NONE |-> last_of_run_o)
    else $error("no-action beat not last of run");

  // A radio hold never lets the target pass the dim rung.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && held_q |-> want_q <= ipls_pkg::RUNG_DIM)
    else $error("radio hold ignored");

  // The current rung only moves on the last beat of a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_rung_q != $past(cur_rung_q) |-> $past(out_acc && last_of_run_o))
    else $error("rung changed outside a run end");

endmodule

`default_nettype wire
